// ===== rtl/wth_pkg.sv =====
// Shared types and constants for the word tokenizer with FNV-1a hashing.
`timescale 1ns / 1ps
`default_nettype none
package wth_pkg;

    // FNV-1a 64-bit constants.
    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01B3;

    // Length counter sizing: the count saturates at the smaller of
    // 2^LENGTH_BITS - 1 and the 16-bit field maximum.
    localparam int LENGTH_BITS = 16;
    localparam int LEN_FIELD_W = 16;
    localparam int LEN_BITS    = (LENGTH_BITS > LEN_FIELD_W) ? LEN_FIELD_W : LENGTH_BITS;

    localparam int HASH_W = 64;
    localparam int DOC_W  = 16;
    localparam int BYTE_W = 8;

    // Character codes used by the classifier.
    localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CHAR_APOS    = 8'h27;
    localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

    // A registered, classified input byte.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] ch;
        logic              letter;
        logic              word_byte;
        logic              last;
    } t_byte_info;

    // One finished word.
    typedef struct packed {
        logic [HASH_W-1:0]      hash;
        logic [LEN_FIELD_W-1:0] length;
        logic [DOC_W-1:0]       doc;
    } t_word;

endpackage
`default_nettype wire

// ===== rtl/wth_in_if.sv =====
// Input channel interface: one text byte per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface wth_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface
`default_nettype wire

// ===== rtl/wth_out_if.sv =====
// Output channel interface: one finished word per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface wth_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] word_hash;
    logic [15:0] word_length;
    logic [15:0] word_doc;

    modport source (output valid, output word_hash, output word_length, output word_doc,
                    input ready);
    modport sink   (input valid, input word_hash, input word_length, input word_doc,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/wth_in_stage.sv =====
// Input register stage: folds case, classifies the byte and holds it for the core.
`timescale 1ns / 1ps
`default_nettype none
module wth_in_stage (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    wth_in_if.sink               i_text,
    input  wire logic            i_advance,
    output wth_pkg::t_byte_info  o_info
);
    import wth_pkg::*;

    t_byte_info r_info;
    t_byte_info n_info;
    logic [BYTE_W-1:0] folded;
    logic accept;

    // The stage can take a byte when empty or when its byte moves on this cycle.
    assign i_text.ready = !r_info.valid || i_advance;
    assign accept       = i_text.valid && i_text.ready;

    // Fold lower case to upper case and classify.
    always_comb begin
        folded = i_text.text_byte;
        if (i_text.text_byte >= CHAR_LOWER_A && i_text.text_byte <= CHAR_LOWER_Z) begin
            folded = i_text.text_byte - CASE_OFFSET;
        end
        n_info.ch        = folded;
        n_info.letter    = (folded >= CHAR_UPPER_A) && (folded <= CHAR_UPPER_Z);
        n_info.word_byte = n_info.letter || (folded == CHAR_APOS);
        n_info.last      = i_text.end_of_text;
        n_info.valid     = accept || (r_info.valid && !i_advance);
    end

    // Valid is control state; the payload loads only on a new transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_info.valid <= 1'b0;
        end else begin
            r_info.valid <= n_info.valid;
        end
        if (accept) begin
            r_info.ch        <= n_info.ch;
            r_info.letter    <= n_info.letter;
            r_info.word_byte <= n_info.word_byte;
            r_info.last      <= n_info.last;
        end
    end

    assign o_info = r_info;

endmodule
`default_nettype wire

// ===== rtl/wth_core.sv =====
// Word state and FNV-1a update: decides word boundaries and forms finished words.
`timescale 1ns / 1ps
`default_nettype none
module wth_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire wth_pkg::t_byte_info        i_info,
    input  wire logic                       i_advance,
    input  wire logic                       i_cfg_we,
    input  wire logic [wth_pkg::DOC_W-1:0]  i_cfg_data,
    output logic                            o_emit,
    output wth_pkg::t_word                  o_word
);
    import wth_pkg::*;

    logic [HASH_W-1:0]   r_hash;
    logic [HASH_W-1:0]   n_hash;
    logic [LEN_BITS-1:0] r_len;
    logic [LEN_BITS-1:0] n_len;
    logic                r_inside;
    logic                n_inside;
    logic [DOC_W-1:0]    r_doc;

    logic                step;
    logic                extend;
    logic                start;
    logic                close;
    logic [HASH_W-1:0]   mix;
    logic [HASH_W-1:0]   upd_hash;
    logic [LEN_BITS-1:0] upd_len;

    // Multiply by the FNV prime 2^40 + 2^8 + 0xB3 as a sum of shifts.
    function automatic logic [HASH_W-1:0] fnv_mult(input logic [HASH_W-1:0] x);
        fnv_mult = x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
    endfunction

    // Classify the transition for the byte that moves on this cycle.
    assign step   = i_info.valid && i_advance;
    assign extend = r_inside && i_info.word_byte;
    assign start  = !r_inside && i_info.letter;
    assign close  = r_inside && !i_info.word_byte;

    // Hash and length after taking in the byte.
    always_comb begin
        mix      = (extend ? r_hash : FNV_BASIS) ^ HASH_W'(i_info.ch);
        upd_hash = fnv_mult(mix);
        if (!extend) begin
            upd_len = LEN_BITS'(1);
        end else if (&r_len) begin
            upd_len = r_len;
        end else begin
            upd_len = r_len + LEN_BITS'(1);
        end
    end

    // Emission and next state.
    always_comb begin
        o_emit      = step && (close || (i_info.last && (extend || start)));
        o_word.hash = close ? r_hash : upd_hash;
        o_word.length = close ? LEN_FIELD_W'(r_len) : LEN_FIELD_W'(upd_len);
        o_word.doc  = r_doc;

        n_hash   = r_hash;
        n_len    = r_len;
        n_inside = r_inside;
        if (step) begin
            if (close || i_info.last) begin
                n_hash   = FNV_BASIS;
                n_len    = '0;
                n_inside = 1'b0;
            end else if (extend || start) begin
                n_hash   = upd_hash;
                n_len    = upd_len;
                n_inside = 1'b1;
            end
        end
    end

    // Word state and the document index register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash   <= FNV_BASIS;
            r_len    <= '0;
            r_inside <= 1'b0;
            r_doc    <= '0;
        end else begin
            r_hash   <= n_hash;
            r_len    <= n_len;
            r_inside <= n_inside;
            if (i_cfg_we) begin
                r_doc <= i_cfg_data;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // After a word is emitted the block is outside any word.
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |=> !r_inside)
        else $error("word state not cleared after emission");

    // Outside a word the running state holds its cleared values.
    a_idle_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_inside |-> (r_len == '0 && r_hash == FNV_BASIS))
        else $error("running state not at basis outside a word");

    // An open word always has at least one byte.
    a_open_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inside |-> (r_len != '0))
        else $error("open word with zero length");
`endif

endmodule
`default_nettype wire

// ===== rtl/wth_out_reg.sv =====
// Output register: holds one finished word until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none
module wth_out_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire wth_pkg::t_word  i_word,
    output logic                 o_free,
    wth_out_if.source            o_word
);
    import wth_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_word r_word;

    // The register is free when empty or when its word leaves this cycle.
    assign o_free  = !r_valid || o_word.ready;
    assign n_valid = i_load || (r_valid && !o_word.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_load) begin
            r_word <= i_word;
        end
    end

    // Drive the channel.
    assign o_word.valid       = r_valid;
    assign o_word.word_hash   = r_word.hash;
    assign o_word.word_length = r_word.length;
    assign o_word.word_doc    = r_word.doc;

endmodule
`default_nettype wire

// ===== rtl/word_tokenizer_fnv1a_hash_top.sv =====
// A byte that ends a word is registered in the input stage; its word then loads the output register once free.
// Throughput: one byte per cycle while the consumer takes words; the hash update is combinational.
// The combinational FNV-1a feedback (xor and shift-add multiply) sets the clock rate.
// Reset is synchronous and active low: no word open, hash at the basis, document index zero.
// Channels are empty after reset; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module word_tokenizer_fnv1a_hash_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    wth_in_if.sink                          i_text,
    wth_out_if.source                       o_word,
    input  wire logic                       i_cfg_we,
    input  wire logic [wth_pkg::DOC_W-1:0]  i_cfg_data
);
    import wth_pkg::*;

    t_byte_info info;
    t_word      word;
    logic       advance;
    logic       emit;

    // Classified input register.
    wth_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_text    (i_text),
        .i_advance (advance),
        .o_info    (info)
    );

    // Word state and hashing.
    wth_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_info     (info),
        .i_advance  (advance),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_emit     (emit),
        .o_word     (word)
    );

    // Result register.
    wth_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (emit),
        .i_word  (word),
        .o_free  (advance),
        .o_word  (o_word)
    );

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the word tokenizer with per-word FNV-1a hashing.
`timescale 1ns / 1ps
module tb_top;
    import wth_pkg::*;

    localparam int          CLK_HALF     = 5;
    localparam int          RESET_CYCLES = 12;
    localparam int          GAP_PERCENT  = 22;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 10;
    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          MAX_REPORTS  = 200;
    localparam int          LONG_WORD    = 48;
    localparam logic [15:0] LEN_CAP      = 16'((32'd1 << LEN_BITS) - 1);
    localparam logic [15:0] DOC_MAX      = 16'hFFFF;
    localparam logic [7:0]  CHAR_SPACE   = 8'h20;
    localparam logic [7:0]  CHAR_AT      = 8'h40;
    localparam logic [7:0]  CHAR_LBRACK  = 8'h5B;
    localparam logic [7:0]  CHAR_BTICK   = 8'h60;
    localparam logic [7:0]  CHAR_LBRACE  = 8'h7B;
    localparam logic [7:0]  CHAR_DEL     = 8'h7F;
    localparam logic [7:0]  CHAR_HIGH    = 8'h80;
    localparam logic [7:0]  CHAR_MAX     = 8'hFF;
    localparam logic [7:0]  CHAR_NUL     = 8'h00;

    typedef struct {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_text_item;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        cfg_we   = 1'b0;
    logic [15:0] cfg_data = '0;

    wth_in_if  txt ();
    wth_out_if wrd ();

    word_tokenizer_fnv1a_hash_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_text     (txt),
        .o_word     (wrd),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    // Stimulus backlog, expected words and the predictor's copy of the block state.
    t_text_item  text_backlog[$];
    t_word       words_due[$];
    logic [63:0] hash_acc;
    logic [15:0] len_acc;
    logic        in_word;
    logic [15:0] doc_cfg;

    bit no_gaps  = 1'b0;
    bit hold_req = 1'b0;
    bit hold_started;
    int hold_left;
    int errors;
    int bytes_taken;
    int words_seen;
    int cycles;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Folds case, updates the running hash and length, and reports a finished word.
    function automatic bit tokenize_byte(input logic [7:0] raw, input logic eot,
                                         output t_word done);
        logic [7:0] c;
        logic       letter;
        logic       word_byte;
        c = raw;
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            c = c - CASE_OFFSET;
        end
        letter    = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z);
        word_byte = letter || (c == CHAR_APOS);
        done      = '0;
        if (in_word && word_byte) begin
            hash_acc = (hash_acc ^ {56'd0, c}) * FNV_PRIME;
            if (len_acc < LEN_CAP) begin
                len_acc = len_acc + 16'd1;
            end
        end else if (!in_word && letter) begin
            hash_acc = (FNV_BASIS ^ {56'd0, c}) * FNV_PRIME;
            len_acc  = 16'd1;
            in_word  = 1'b1;
        end else if (in_word) begin
            done     = '{hash: hash_acc, length: len_acc, doc: doc_cfg};
            hash_acc = FNV_BASIS;
            len_acc  = '0;
            in_word  = 1'b0;
            return 1'b1;
        end
        if (eot) begin
            done     = '{hash: hash_acc, length: len_acc, doc: doc_cfg};
            hash_acc = FNV_BASIS;
            len_acc  = '0;
            if (in_word) begin
                in_word = 1'b0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Predictor: follows configuration writes and every accepted byte.
    always @(posedge i_clk) begin : predict_blk
        t_word w;
        if (!i_rst_n) begin
            hash_acc = FNV_BASIS;
            len_acc  = '0;
            in_word  = 1'b0;
            doc_cfg  = '0;
        end else begin
            if (cfg_we) begin
                doc_cfg = cfg_data;
            end
            if (txt.valid && txt.ready) begin
                bytes_taken++;
                if (tokenize_byte(txt.text_byte, txt.end_of_text, w)) begin
                    words_due.insert(words_due.size(), w);
                end
            end
        end
    end

    // Driver: offers backlog bytes with random gaps and holds them until taken.
    always @(posedge i_clk) begin : driver_blk
        t_text_item it;
        if (!i_rst_n) begin
            txt.valid <= 1'b0;
        end else if (!txt.valid || txt.ready) begin
            if (text_backlog.size() != 0 &&
                (no_gaps || $urandom_range(99) >= GAP_PERCENT)) begin
                it = text_backlog.pop_front();
                txt.valid       <= 1'b1;
                txt.text_byte   <= it.text_byte;
                txt.end_of_text <= it.end_of_text;
            end else begin
                txt.valid <= 1'b0;
            end
        end
    end

    // Word sink: random stalls, plus one long hold-off when requested.
    always @(posedge i_clk) begin : sink_blk
        if (!i_rst_n) begin
            wrd.ready    <= 1'b0;
            hold_started  = 1'b0;
            hold_left     = 0;
        end else if (hold_req && !hold_started) begin
            hold_started  = 1'b1;
            hold_left     = HOLD_CYCLES;
            wrd.ready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            wrd.ready <= 1'b0;
        end else begin
            wrd.ready <= no_gaps || ($urandom_range(99) >= GAP_PERCENT);
        end
    end

    // Monitor: every word transaction is checked against the oldest expectation.
    always @(posedge i_clk) begin : monitor_blk
        t_word want;
        if (i_rst_n && wrd.valid && wrd.ready) begin
            words_seen++;
            if (words_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: unexpected word: expected none, actual hash %h len %0d doc %0d",
                             $time, wrd.word_hash, wrd.word_length, wrd.word_doc);
                end
            end else begin
                want = words_due.pop_front();
                if (wrd.word_hash !== want.hash) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("%0t: word_hash mismatch: expected %h, actual %h",
                                 $time, want.hash, wrd.word_hash);
                    end
                end
                if (wrd.word_length !== want.length) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("%0t: word_length mismatch: expected %0d, actual %0d",
                                 $time, want.length, wrd.word_length);
                    end
                end
                if (wrd.word_doc !== want.doc) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("%0t: word_doc mismatch: expected %0d, actual %0d",
                                 $time, want.doc, wrd.word_doc);
                    end
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d words outstanding",
                     cycles, words_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic eot);
        text_backlog.insert(text_backlog.size(), '{text_byte: b, end_of_text: eot});
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] base;
        base = $urandom_range(1) ? CHAR_UPPER_A : CHAR_LOWER_A;
        return base + 8'($urandom_range(25));
    endfunction

    // Random text: mostly words with random case and apostrophes, the rest noise.
    task automatic queue_text(input int n_items, input bit short_words);
        int start;
        int len;
        int r;
        start = text_backlog.size();
        while (text_backlog.size() - start < n_items) begin
            r = $urandom_range(99);
            if (r < 70) begin
                len = short_words ? $urandom_range(2, 1) : $urandom_range(10, 1);
                push_byte(rand_letter(), 1'b0);
                for (int i = 1; i < len; i++) begin
                    push_byte(($urandom_range(99) < 12) ? CHAR_APOS : rand_letter(), 1'b0);
                end
                r = $urandom_range(99);
                if (r < 5) begin
                    text_backlog[text_backlog.size() - 1].end_of_text = 1'b1;
                end else if (r < 60) begin
                    push_byte(CHAR_SPACE, 1'b0);
                end else if (r < 75) begin
                    push_byte(8'($urandom_range(8'h3F, 8'h21)), 1'b0);
                end else if (r < 90) begin
                    push_byte(8'($urandom_range(255)), 1'b0);
                end else begin
                    push_byte(8'($urandom_range(255)), 1'b1);
                end
            end else if (r < 80) begin
                push_byte(CHAR_APOS, $urandom_range(19) == 0);
            end else begin
                push_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
            end
        end
        // Close each phase with no word left open.
        push_byte(CHAR_SPACE, 1'b1);
    endtask

    // Waits until every byte is taken and every word has come out.
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
        end while (text_backlog.size() != 0 || txt.valid || words_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_doc(input logic [15:0] value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Test sequence: directed corner cases, then random phases under several settings.
    initial begin
        txt.valid       = 1'b0;
        txt.text_byte   = '0;
        txt.end_of_text = 1'b0;
        wrd.ready       = 1'b0;
        errors          = 0;
        bytes_taken     = 0;
        words_seen      = 0;
        cycles          = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset document index.
        push_byte(CHAR_APOS, 1'b0);     // an apostrophe cannot open a word
        push_byte("a", 1'b0);
        push_byte("Z", 1'b0);
        push_byte(CHAR_APOS, 1'b0);
        push_byte(CHAR_NUL, 1'b0);
        push_byte(CHAR_AT, 1'b0);       // neighbors of the letter ranges
        push_byte(CHAR_LBRACK, 1'b0);
        push_byte(CHAR_BTICK, 1'b0);
        push_byte(CHAR_LBRACE, 1'b0);
        push_byte("z", 1'b0);
        push_byte(CHAR_MAX, 1'b0);      // high bytes end a word
        push_byte("A", 1'b0);
        push_byte(CHAR_HIGH, 1'b0);
        push_byte("m", 1'b0);
        push_byte("q", 1'b1);           // end of text on a letter
        push_byte("b", 1'b0);
        push_byte(CHAR_SPACE, 1'b1);    // end of text on a separator with a word open
        push_byte(CHAR_SPACE, 1'b1);    // end of text with nothing open
        push_byte(CHAR_DEL, 1'b0);
        push_byte("x", 1'b1);
        wait_drained();

        write_doc(DOC_MAX);
        queue_text(250, 1'b0);
        wait_drained();

        // One long word and a stretch of random text, with no idling on either side.
        write_doc('0);
        no_gaps = 1'b1;
        push_byte(rand_letter(), 1'b0);
        for (int i = 1; i < LONG_WORD; i++) begin
            push_byte(($urandom_range(99) < 5) ? CHAR_APOS : rand_letter(), 1'b0);
        end
        push_byte(CHAR_SPACE, 1'b1);
        queue_text(150, 1'b0);
        wait_drained();
        no_gaps = 1'b0;

        // Short words while the sink holds off, so the block backs up.
        write_doc(16'($urandom));
        hold_req = 1'b1;
        queue_text(150, 1'b1);
        wait_drained();

        write_doc(16'($urandom));
        queue_text(250, 1'b0);
        wait_drained();

        write_doc(16'($urandom));
        queue_text(250, 1'b0);
        wait_drained();

        $display("Run covered %0d text bytes and %0d checked words across six phases,",
                 bytes_taken, words_seen);
        $display("including a long word, a stretch without idling and a long output stall.");
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== word_tokenizer_fnv1a_hash_top.f =====
rtl/wth_pkg.sv
rtl/wth_in_if.sv
rtl/wth_out_if.sv
rtl/wth_in_stage.sv
rtl/wth_core.sv
rtl/wth_out_reg.sv
rtl/word_tokenizer_fnv1a_hash_top.sv
test/tb_top.sv
